// ===== hdl/smbs_pkg.sv =====
// Shared types and constants for the SPI master bit shifter.
package smbs_pkg;

  localparam int unsigned DelayBits = 12;
  localparam int unsigned CfgIdxBits = 3;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegClockPolarity = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegClockPhase    = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegLsbFirst      = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegHalfPeriod    = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegEndClockLevel = 3'd4;

  typedef struct packed {
    logic       load;
    logic [7:0] tx_byte;
    logic [3:0] bit_count;
    logic       final_hold;
    logic       miso_level;
  } in_item_t;

  typedef struct packed {
    logic       sck_pin;
    logic       mosi_pin;
    logic       busy_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } out_item_t;

  typedef struct packed {
    logic                 clock_polarity;
    logic                 clock_phase;
    logic                 lsb_first;
    logic [DelayBits-1:0] half_period;
    logic                 end_clock_level;
  } cfg_t;

  // One tick after classification: byte already aligned, count already clamped (8 when LSB first)
  typedef struct packed {
    logic       load;
    logic [7:0] shift_init;
    logic [3:0] bits;
    logic       final_hold;
    logic       miso_level;
  } cmd_t;

  typedef enum logic [1:0] {
    PhIdle,
    PhFirst,
    PhSecond
  } phase_e;

endpackage

// ===== hdl/smbs_front.sv =====
// Front stage: takes input beats, clamps the bit count and aligns the byte (LSB first: all 8 bits, byte as is).
module smbs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smbs_pkg::cfg_t    cfg_i,
  input  logic              push,
  output logic              full,
  input  smbs_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output smbs_pkg::cmd_t    cmd_o
);

  logic           valid_q, valid_d;
  smbs_pkg::cmd_t cmd_q, cmd_d;
  logic [3:0]     cnt;
  logic [2:0]     sh;
  logic           take;

  assign full = valid_q && !cmd_ready_i;
  assign take = push && !full;

  always_comb begin
    if (in_item_i.bit_count == 4'd0) begin
      cnt = 4'd1;
    end else if (in_item_i.bit_count > 4'd8) begin
      cnt = 4'd8;
    end else begin
      cnt = in_item_i.bit_count;
    end
    sh = 3'(4'd8 - cnt);

    cmd_d.load       = in_item_i.load;
    cmd_d.final_hold = in_item_i.final_hold;
    cmd_d.miso_level = in_item_i.miso_level;
    if (cfg_i.lsb_first) begin
      cmd_d.shift_init = in_item_i.tx_byte;
      cmd_d.bits       = 4'd8;
    end else begin
      // MSB first: move the low bits up to the top of the shifter
      cmd_d.shift_init = 8'(in_item_i.tx_byte << sh);
      cmd_d.bits       = cnt;
    end

    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ===== hdl/smbs_cmd_queue.sv =====
// Two-entry queue of classified ticks between front and back.
module smbs_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  smbs_pkg::cmd_t wr_cmd_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output smbs_pkg::cmd_t rd_cmd_o
);

  smbs_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           wr_fire, rd_fire;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign rd_cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_fire ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_fire ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_fire && !rd_fire) begin
      cnt_d = 2'(cnt_q + 2'd1);
    end else if (rd_fire && !wr_fire) begin
      cnt_d = 2'(cnt_q - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

// ===== hdl/smbs_back.sv =====
// Back stage: runs the SCK/MOSI tick engine and buffers result beats.
module smbs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smbs_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  smbs_pkg::cmd_t      cmd_i,
  output logic                empty,
  input  logic                pop,
  output smbs_pkg::out_item_t out_item_o
);

  smbs_pkg::phase_e             state_q, state_d;
  logic [7:0]                   shift_q, shift_d;
  logic [3:0]                   bits_q, bits_d;
  logic [smbs_pkg::DelayBits-1:0] tick_q, tick_d;
  logic                         hold_q, hold_d;
  logic                         sck_q, sck_d;
  logic                         mosi_q, mosi_d;

  smbs_pkg::out_item_t res;
  smbs_pkg::out_item_t res_mem_q [2];
  logic                res_wr_q, res_rd_q;
  logic [1:0]          res_cnt_q, res_cnt_d;
  logic                pop_fire, room, step;
  logic [7:0]          sh;
  logic                last;

  function automatic logic out_bit(input logic lsb, input logic [7:0] s);
    return lsb ? s[0] : s[7];
  endfunction

  function automatic logic [7:0] take_bit(input logic lsb, input logic [7:0] s,
                                          input logic miso);
    return lsb ? {miso, s[7:1]} : {s[6:0], miso};
  endfunction

  assign pop_fire    = pop && !empty;
  assign empty       = res_cnt_q == 2'd0;
  assign room        = (res_cnt_q != 2'd2) || pop_fire;
  assign step        = cmd_valid_i && room;
  assign cmd_ready_o = room;
  assign out_item_o  = res_mem_q[res_rd_q];

  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    tick_d  = tick_q;
    hold_d  = hold_q;
    sck_d   = sck_q;
    mosi_d  = mosi_q;
    sh      = shift_q;
    last    = 1'b0;
    res.rx_valid = 1'b0;
    res.rx_byte  = 8'd0;

    case (state_q)
      smbs_pkg::PhIdle: begin
        if (cmd_i.load) begin
          shift_d = cmd_i.shift_init;
          bits_d  = cmd_i.bits;
          hold_d  = cmd_i.final_hold;
          if (!cfg_i.clock_phase) begin
            mosi_d = out_bit(cfg_i.lsb_first, cmd_i.shift_init);
          end
          sck_d   = 1'b1;
          tick_d  = smbs_pkg::DelayBits'(1);
          state_d = smbs_pkg::PhFirst;
        end
      end
      smbs_pkg::PhFirst: begin
        if (tick_q < cfg_i.half_period) begin
          tick_d = smbs_pkg::DelayBits'(tick_q + 1'b1);
        end else begin
          last = hold_q && (bits_q <= 4'd1);
          if (cfg_i.clock_phase) begin
            mosi_d = out_bit(cfg_i.lsb_first, shift_q);
          end else begin
            shift_d = take_bit(cfg_i.lsb_first, shift_q, cmd_i.miso_level);
          end
          sck_d   = last ? cfg_i.end_clock_level : 1'b0;
          tick_d  = smbs_pkg::DelayBits'(1);
          state_d = smbs_pkg::PhSecond;
        end
      end
      smbs_pkg::PhSecond: begin
        if (tick_q < cfg_i.half_period) begin
          tick_d = smbs_pkg::DelayBits'(tick_q + 1'b1);
        end else begin
          if (cfg_i.clock_phase) begin
            sh = take_bit(cfg_i.lsb_first, shift_q, cmd_i.miso_level);
          end
          shift_d = sh;
          bits_d  = 4'(bits_q - 4'd1);
          if (bits_d != 4'd0) begin
            if (!cfg_i.clock_phase) begin
              mosi_d = out_bit(cfg_i.lsb_first, sh);
            end
            sck_d   = 1'b1;
            tick_d  = smbs_pkg::DelayBits'(1);
            state_d = smbs_pkg::PhFirst;
          end else begin
            // Byte done: drop to idle and hand back what was shifted in
            tick_d       = '0;
            state_d      = smbs_pkg::PhIdle;
            res.rx_valid = 1'b1;
            res.rx_byte  = sh;
          end
        end
      end
      default: begin
        state_d = smbs_pkg::PhIdle;
      end
    endcase

    res.sck_pin  = sck_d ^ cfg_i.clock_polarity;
    res.mosi_pin = mosi_d;
    res.busy_res = state_d != smbs_pkg::PhIdle;

    res_cnt_d = res_cnt_q;
    if (step && !pop_fire) begin
      res_cnt_d = 2'(res_cnt_q + 2'd1);
    end else if (pop_fire && !step) begin
      res_cnt_d = 2'(res_cnt_q - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= smbs_pkg::PhIdle;
      shift_q   <= 8'd0;
      bits_q    <= 4'd0;
      tick_q    <= '0;
      hold_q    <= 1'b0;
      sck_q     <= 1'b0;
      mosi_q    <= 1'b1;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (step) begin
        state_q  <= state_d;
        shift_q  <= shift_d;
        bits_q   <= bits_d;
        tick_q   <= tick_d;
        hold_q   <= hold_d;
        sck_q    <= sck_d;
        mosi_q   <= mosi_d;
        res_wr_q <= !res_wr_q;
      end
      if (pop_fire) begin
        res_rd_q <= !res_rd_q;
      end
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_mem_q[res_wr_q] <= res;
    end
  end

  a_tick_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != smbs_pkg::PhIdle) |-> (tick_q != '0))
    else $error("tick counter zero while shifting");

  a_res_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= 2'd2)
    else $error("result buffer overfilled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.rx_valid) |=> (state_q == smbs_pkg::PhIdle))
    else $error("engine not idle after completed byte");

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (res_cnt_q != 2'd0))
    else $error("result beat lost after step");

endmodule

// ===== hdl/spi_master_bit_shifter.sv =====
// SPI master bit shifter top level: config registers, front, queue and back.
// Each input beat is one tick; a new beat is taken every cycle when results are popped.
// An accepted beat is registered in the front stage, the queue and the result buffer.
// Throughput: one beat per cycle while results are popped, set by the tick engine.
// Reset clears config to polarity 0, phase 0, MSB first, half period 1, end level 0,
// idles the engine with SCK inactive and MOSI high, and empties every queue.
module spi_master_bit_shifter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [smbs_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [smbs_pkg::DelayBits-1:0]      cfg_wdata_i,
  input  logic                                push,
  output logic                                full,
  input  smbs_pkg::in_item_t                  in_item_i,
  output logic                                empty,
  input  logic                                pop,
  output smbs_pkg::out_item_t                 out_item_o
);

  smbs_pkg::cfg_t cfg_q, cfg_d;
  logic           f_valid, f_ready;
  smbs_pkg::cmd_t f_cmd;
  logic           b_valid, b_ready;
  smbs_pkg::cmd_t b_cmd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        smbs_pkg::RegClockPolarity: cfg_d.clock_polarity  = cfg_wdata_i[0];
        smbs_pkg::RegClockPhase:    cfg_d.clock_phase     = cfg_wdata_i[0];
        smbs_pkg::RegLsbFirst:      cfg_d.lsb_first       = cfg_wdata_i[0];
        smbs_pkg::RegHalfPeriod:    cfg_d.half_period     = cfg_wdata_i;
        smbs_pkg::RegEndClockLevel: cfg_d.end_clock_level = cfg_wdata_i[0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_polarity  <= 1'b0;
      cfg_q.clock_phase     <= 1'b0;
      cfg_q.lsb_first       <= 1'b0;
      cfg_q.half_period     <= smbs_pkg::DelayBits'(1);
      cfg_q.end_clock_level <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  smbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  smbs_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_cmd_i   (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_cmd_o   (b_cmd)
  );

  smbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the SPI master bit shifter: one tick per beat, checked per output field.
module testbench;

  localparam int DirRows = 24;
  localparam int Phases = 12;
  localparam int LongHold = 80;

  typedef struct packed {
    smbs_pkg::in_item_t  stim;
    logic                typed;
    smbs_pkg::out_item_t want;
  } dir_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [smbs_pkg::CfgIdxBits-1:0] cfg_idx_i = smbs_pkg::RegClockPolarity;
  logic [smbs_pkg::DelayBits-1:0]  cfg_wdata_i = '0;
  logic                            push = 1'b0;
  logic                            full;
  smbs_pkg::in_item_t              in_item_i = '0;
  logic                            empty;
  logic                            pop = 1'b0;
  smbs_pkg::out_item_t             out_item_o;

  spi_master_bit_shifter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Shifter image: configuration plus engine state
  smbs_pkg::cfg_t                 sh_cfg;
  logic [7:0]                     shreg;
  logic [3:0]                     bits_left;
  logic [smbs_pkg::DelayBits-1:0] tick_cnt;
  logic                           in_second;
  logic                           running;
  logic                           hold_latched;
  logic                           sck_lvl;
  logic                           mosi_lvl;

  smbs_pkg::out_item_t pins_due_q[$];
  int                  errors = 0;
  int                  send_gap_pct = 0;
  int                  stall_pct = 0;
  int                  hold_off_reqs = 0;

  // Reset config: polarity 0, phase 0, MSB first, half period 1
  dir_row_t dir_tab [DirRows] = '{
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{'{1'b1, 8'h01, 4'd0,  1'b0, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00}},
    '{'{1'b1, 8'hFF, 4'd15, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00}},
    '{'{1'b0, 8'h00, 4'd8,  1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h01}},
    '{'{1'b1, 8'hFF, 4'd1,  1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd1,  1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 8'hFF, 4'd8,  1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 8'h5A, 4'd15, 1'b0, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00}},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'hFF, 4'd9,  1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'hFF, 4'd15, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 8'h00, 4'd0,  1'b0, 1'b0}, 1'b0, '0}
  };

  int unsigned half_plan [Phases] = '{2, 1, 0, 3, 4095, 1, 4, 2, 1, 3, 2, 1};

  function automatic logic next_out_bit();
    return sh_cfg.lsb_first ? shreg[0] : shreg[7];
  endfunction

  function automatic void sample_miso(input logic m);
    if (sh_cfg.lsb_first) begin
      shreg = {m, shreg[7:1]};
    end else begin
      shreg = {shreg[6:0], m};
    end
  endfunction

  function automatic void open_first_half();
    if (!sh_cfg.clock_phase) begin
      mosi_lvl = next_out_bit();
    end
    sck_lvl = 1'b1;
    in_second = 1'b0;
    tick_cnt = smbs_pkg::DelayBits'(1);
  endfunction

  // Advance the shifter image by one tick and return the pins it shows afterwards
  function automatic smbs_pkg::out_item_t shifter_tick(input smbs_pkg::in_item_t it);
    smbs_pkg::out_item_t r;
    logic [3:0]          n;
    logic                last;
    r = '0;
    if (!running) begin
      if (it.load) begin
        n = it.bit_count;
        if (n == 4'd0) n = 4'd1;
        if (n > 4'd8) n = 4'd8;
        if (sh_cfg.lsb_first) begin
          n = 4'd8;
          shreg = it.tx_byte;
        end else begin
          shreg = it.tx_byte << (8 - n);
        end
        bits_left = n;
        hold_latched = it.final_hold;
        running = 1'b1;
        open_first_half();
      end
    end else if (tick_cnt < sh_cfg.half_period) begin
      tick_cnt = tick_cnt + 1'b1;
    end else if (!in_second) begin
      last = hold_latched && (bits_left <= 4'd1);
      if (sh_cfg.clock_phase) begin
        mosi_lvl = next_out_bit();
      end else begin
        sample_miso(it.miso_level);
      end
      sck_lvl = last ? sh_cfg.end_clock_level : 1'b0;
      in_second = 1'b1;
      tick_cnt = smbs_pkg::DelayBits'(1);
    end else begin
      if (sh_cfg.clock_phase) sample_miso(it.miso_level);
      bits_left = bits_left - 1'b1;
      if (bits_left != 4'd0) begin
        open_first_half();
      end else begin
        running = 1'b0;
        in_second = 1'b0;
        tick_cnt = '0;
        r.rx_valid = 1'b1;
        r.rx_byte = shreg;
      end
    end
    r.sck_pin = sck_lvl ^ sh_cfg.clock_polarity;
    r.mosi_pin = mosi_lvl;
    r.busy_res = running;
    return r;
  endfunction

  // Offer one tick; returns at the falling edge after the beat is taken, or later after a random send gap
  task automatic send_tick(input smbs_pkg::in_item_t it, input logic typed,
                           input smbs_pkg::out_item_t want);
    smbs_pkg::out_item_t pred;
    in_item_i = it;
    push = 1'b1;
    do begin
      @(posedge clk_i);
    end while (full);
    pred = shifter_tick(it);
    pins_due_q.push_back(typed ? want : pred);
    @(negedge clk_i);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      push = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    push = 1'b0;
    while (pins_due_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [smbs_pkg::CfgIdxBits-1:0] idx,
                           input logic [smbs_pkg::DelayBits-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    case (idx)
      smbs_pkg::RegClockPolarity: sh_cfg.clock_polarity = val[0];
      smbs_pkg::RegClockPhase:    sh_cfg.clock_phase = val[0];
      smbs_pkg::RegLsbFirst:      sh_cfg.lsb_first = val[0];
      smbs_pkg::RegHalfPeriod:    sh_cfg.half_period = val;
      smbs_pkg::RegEndClockLevel: sh_cfg.end_clock_level = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Result side: random pop stalls, long hold-off on request, per-field check
  initial begin : result_side
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pins_due_q.size() == 0) begin
          $error("result beat with no tick pending: %h", out_item_o);
          errors++;
        end else begin : cmp
          smbs_pkg::out_item_t due;
          due = pins_due_q.pop_front();
          if (out_item_o.sck_pin !== due.sck_pin) begin
            $error("sck_pin: expected %0d, got %0d", due.sck_pin, out_item_o.sck_pin);
            errors++;
          end
          if (out_item_o.mosi_pin !== due.mosi_pin) begin
            $error("mosi_pin: expected %0d, got %0d", due.mosi_pin, out_item_o.mosi_pin);
            errors++;
          end
          if (out_item_o.busy_res !== due.busy_res) begin
            $error("busy_res: expected %0d, got %0d", due.busy_res, out_item_o.busy_res);
            errors++;
          end
          if (out_item_o.rx_valid !== due.rx_valid) begin
            $error("rx_valid: expected %0d, got %0d", due.rx_valid, out_item_o.rx_valid);
            errors++;
          end
          if (out_item_o.rx_byte !== due.rx_byte) begin
            $error("rx_byte: expected %h, got %h", due.rx_byte, out_item_o.rx_byte);
            errors++;
          end
        end
      end
      @(negedge clk_i);
      if (hold_off_reqs != holds_done) begin
        holds_done++;
        stall_left = LongHold;
      end else if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
      end
    end
  end

  initial begin : stimulus
    smbs_pkg::in_item_t it;
    logic [3:0]         sel;
    int                 items;
    sh_cfg = '0;
    sh_cfg.half_period = smbs_pkg::DelayBits'(1);
    shreg = '0;
    bits_left = '0;
    tick_cnt = '0;
    in_second = 1'b0;
    running = 1'b0;
    hold_latched = 1'b0;
    sck_lvl = 1'b0;
    mosi_lvl = 1'b1;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_gap_pct = 15;
    stall_pct = 20;
    for (int r = 0; r < DirRows; r++) begin
      send_tick(dir_tab[r].stim, dir_tab[r].typed, dir_tab[r].want);
    end

    for (int ph = 0; ph < Phases; ph++) begin
      drain();
      sel = 4'(ph);
      write_reg(smbs_pkg::RegClockPolarity, {11'($urandom), sel[0]});
      write_reg(smbs_pkg::RegClockPhase, {11'($urandom), sel[1]});
      write_reg(smbs_pkg::RegLsbFirst, {11'($urandom), sel[2]});
      write_reg(smbs_pkg::RegEndClockLevel, {11'($urandom), sel[1] ^ sel[3]});
      write_reg(smbs_pkg::RegHalfPeriod, smbs_pkg::DelayBits'(half_plan[ph]));
      // no send gaps or pop stalls in phase 3 and in the closing phases
      send_gap_pct = (ph == 3 || ph >= 10) ? 0 : 15;
      stall_pct = (ph == 3 || ph >= 10) ? 0 : 20;
      items = (half_plan[ph] > 100) ? 40 : 45;
      for (int n = 0; n < items; n++) begin
        if (ph == 6 && n == 5) hold_off_reqs++;
        if (ph == 7 && n == 20) drain();
        it.load = ($urandom_range(0, 3) != 0);
        it.tx_byte = 8'($urandom);
        it.bit_count = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(1, 8));
        it.final_hold = ($urandom_range(0, 2) == 0);
        it.miso_level = 1'($urandom);
        send_tick(it, 1'b0, '0);
      end
    end

    drain();
    repeat (16) @(negedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
